@@ rtl/ilp_pkg.sv @@
// Shared types, codes and character constants for the integer literal parser.
package ilp_pkg;

   // Width of the accumulated value; results are sign-extended from its top bit
   localparam int VALUE_BITS = 64;
   localparam int OUT_BITS   = 64;

   // Characters with a meaning of their own
   localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_LO_X  = 8'h78;  // 'x'
   localparam logic [7:0] CH_LO_H  = 8'h68;  // 'h'
   localparam logic [7:0] CH_LO_D  = 8'h64;  // 'd'
   localparam logic [7:0] CH_LO_O  = 8'h6F;  // 'o'
   localparam logic [7:0] CH_LO_B  = 8'h62;  // 'b'
   localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
   localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
   localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
   localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_FROZEN = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_OCT = 2'd2,
      RX_BIN = 2'd3
   } radix_type;

   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_SIGN_ONLY = 2'd2;

   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] parsed_value;
      logic [1:0]                 status;
   } rsp_type;

   typedef struct packed {
      phase_type              phase;
      logic                   negative;
      radix_type              radix;
      logic [VALUE_BITS-1:0]  acc;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:    PH_FIRST,
      negative: 1'b0,
      radix:    RX_DEC,
      acc:      '0
   };

endpackage

@@ rtl/ilp_digit.sv @@
// Digit decoder: value of one character and whether it is a digit of the radix.
module ilp_digit import ilp_pkg::*; (
   input  logic [7:0] character,
   input  radix_type  radix,
   output logic [3:0] digit,
   output logic       digit_ok
);

   logic is_num;
   logic is_lo;
   logic is_up;

   // Classify the character
   always_comb begin
      is_num = (character >= CH_ZERO) && (character <= CH_NINE);
      is_lo  = (character >= CH_LO_A) && (character <= CH_LO_F);
      is_up  = (character >= CH_UP_A) && (character <= CH_UP_F);
   end

   // Map to a digit value; letters count from ten
   always_comb begin
      priority if (is_num) begin
         digit = 4'(character - CH_ZERO);
      end else if (is_lo) begin
         digit = 4'(character - CH_LO_A + 8'd10);
      end else if (is_up) begin
         digit = 4'(character - CH_UP_A + 8'd10);
      end else begin
         digit = 4'd0;
      end
   end

   // Check the digit against the radix
   always_comb begin
      unique case (radix)
         RX_HEX: digit_ok = is_num || is_lo || is_up;
         RX_OCT: digit_ok = is_num && (digit < 4'd8);
         RX_BIN: digit_ok = is_num && (digit < 4'd2);
         default: digit_ok = is_num;
      endcase
   end

endmodule

@@ rtl/ilp_step.sv @@
// One parse step: next parser state and the result for one character.
module ilp_step import ilp_pkg::*; (
   input  state_type state_cur,
   input  req_type   word,
   output state_type state_nxt,
   output rsp_type   result
);

   logic [3:0]            digit;
   logic                  digit_ok;
   logic [VALUE_BITS-1:0] acc_scaled;
   logic [VALUE_BITS-1:0] acc_digit;
   logic [VALUE_BITS-1:0] mag;
   logic signed [VALUE_BITS-1:0] value;
   logic                  sign_only;

   ilp_digit u_digit (
      .character (word.character),
      .radix     (state_cur.radix),
      .digit     (digit),
      .digit_ok  (digit_ok)
   );

   // Scale the accumulator by the radix with shifts, then add the digit
   always_comb begin
      unique case (state_cur.radix)
         RX_HEX: acc_scaled = {state_cur.acc[VALUE_BITS-5:0], 4'b0000};
         RX_OCT: acc_scaled = {state_cur.acc[VALUE_BITS-4:0], 3'b000};
         RX_BIN: acc_scaled = {state_cur.acc[VALUE_BITS-2:0], 1'b0};
         default: acc_scaled = {state_cur.acc[VALUE_BITS-4:0], 3'b000}
                             + {state_cur.acc[VALUE_BITS-2:0], 1'b0};
      endcase
      acc_digit = acc_scaled + VALUE_BITS'(digit);
   end

   // Advance the phase for this character
   always_comb begin
      state_nxt = state_cur;
      sign_only = 1'b0;
      unique case (state_cur.phase)
         PH_FIRST: begin
            priority if (word.character == CH_MINUS || word.character == CH_PLUS) begin
               state_nxt.negative = (word.character == CH_MINUS);
               state_nxt.phase    = PH_SIGNED;
               sign_only          = 1'b1;
            end else if (word.character == CH_ZERO) begin
               state_nxt.phase = PH_ZERO;
            end else if (digit_ok) begin
               state_nxt.acc   = acc_digit;
               state_nxt.phase = PH_DIGITS;
            end else begin
               state_nxt.phase = PH_FROZEN;
            end
         end
         PH_SIGNED: begin
            priority if (word.character == CH_ZERO) begin
               state_nxt.phase = PH_ZERO;
            end else if (digit_ok) begin
               state_nxt.acc   = acc_digit;
               state_nxt.phase = PH_DIGITS;
            end else begin
               state_nxt.phase = PH_FROZEN;
            end
         end
         PH_ZERO: begin
            priority if (word.character == CH_LO_X || word.character == CH_LO_H) begin
               state_nxt.radix = RX_HEX;
               state_nxt.phase = PH_DIGITS;
            end else if (word.character == CH_LO_D) begin
               state_nxt.radix = RX_DEC;
               state_nxt.phase = PH_DIGITS;
            end else if (word.character == CH_LO_O) begin
               state_nxt.radix = RX_OCT;
               state_nxt.phase = PH_DIGITS;
            end else if (word.character == CH_LO_B) begin
               state_nxt.radix = RX_BIN;
               state_nxt.phase = PH_DIGITS;
            end else if (digit_ok) begin
               state_nxt.acc   = acc_digit;
               state_nxt.phase = PH_DIGITS;
            end else begin
               state_nxt.phase = PH_FROZEN;
            end
         end
         PH_DIGITS: begin
            if (digit_ok) begin
               state_nxt.acc = acc_digit;
            end else begin
               state_nxt.phase = PH_FROZEN;
            end
         end
         default: begin
            state_nxt.phase = PH_FROZEN;
         end
      endcase
   end

   // Form the signed result from the updated state
   always_comb begin
      mag   = state_nxt.negative ? (VALUE_BITS'(0) - state_nxt.acc) : state_nxt.acc;
      value = mag;
      if (sign_only) begin
         result.parsed_value = '0;
         result.status       = ST_SIGN_ONLY;
      end else begin
         result.parsed_value = OUT_BITS'(value);
         result.status       = (state_nxt.phase == PH_FROZEN) ? ST_INVALID : ST_VALID;
      end
   end

endmodule

@@ rtl/integer_literal_parser.sv @@
// Top level of the integer literal parser: input register, parse step, result register.
//
// Feed one character of the literal per word, with last_char set on the final one;
// each literal yields exactly one result word, issued with its last character.
// A word is taken every cycle unless a last character is stalled: the input register
// feeds a combinational parse step (shift-and-add by the radix, 64-bit adds) that updates
// the parser state and, on the last character, loads the result register, which then
// raises rsp_valid. Only a last character waiting on a full, stalled result register
// holds the input side; characters that are not last never stall the step.
module integer_literal_parser import ilp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_word_ff;
   state_type state_ff;
   state_type state_in;
   state_type state_nxt;
   rsp_type   step_rsp;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_word_ff;
   logic      step_go;
   logic      out_free;

   ilp_step u_step (
      .state_cur (state_ff),
      .word      (in_word_ff),
      .state_nxt (state_nxt),
      .result    (step_rsp)
   );

   // Advance the held word unless it is a last character blocked at the output
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      step_go      = in_valid_ff && (!in_word_ff.last_char || out_free);
      req_ready    = !in_valid_ff || step_go;
      in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !step_go);
      rsp_valid_in = (step_go && in_word_ff.last_char) ? 1'b1
                   : (rsp_valid_ff && !rsp_ready);
      state_in     = state_ff;
      if (step_go) begin
         state_in = in_word_ff.last_char ? STATE_RESET : state_nxt;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (step_go && in_word_ff.last_char) begin
         rsp_word_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // A finished literal leaves the parser ready for a new one
   a_restart: assert property (@(posedge clock) disable iff (reset)
      step_go && in_word_ff.last_char |=> state_ff.phase == PH_FIRST && !state_ff.negative)
      else $error("parser state not cleared after last character");

   // The input side waits only on a last character behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_go |-> in_word_ff.last_char && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without cause");

   // A sign alone always reports zero
   a_sign_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == ST_SIGN_ONLY |-> rsp_word_ff.parsed_value == '0)
      else $error("sign-only result carries a value");
`endif

endmodule
